FILE: rtl/core/file_share_access_table_core_defines.svh
// Assertion macros for the file share access table core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef FILE_SHARE_ACCESS_TABLE_CORE_DEFINES_SVH
`define FILE_SHARE_ACCESS_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fsat_pkg.sv
// Shared types and constants of the file share access table core.
// No dependencies; imported by the interfaces and all modules.
package fsat_pkg;

	localparam int NUM_FILES_DEF  = 256;
	localparam int COUNT_BITS_DEF = 16;

	localparam int REQ_TYPE_W    = 2;
	localparam int FILE_ID_W     = 8;
	localparam int ACCESS_W      = 32;
	localparam int SHARE_W       = 3;
	localparam int STATUS_W      = 2;
	localparam int OPEN_AFTER_W  = 16;
	localparam int FILE_ID_RANGE = 1 << FILE_ID_W;

	// Request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_CHECK  = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_SET    = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_VIOLATION = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

	// Access mask bits that map to read, write and delete
	localparam logic [ACCESS_W-1:0] ACC_READ_MASK   = 32'h0000_0021;
	localparam logic [ACCESS_W-1:0] ACC_WRITE_MASK  = 32'h0000_0006;
	localparam logic [ACCESS_W-1:0] ACC_DELETE_MASK = 32'h0001_0000;

	// Counter slots within one table entry
	localparam int K_NUM  = 7;
	localparam int K_OPEN = 0;
	localparam int K_RD   = 1;
	localparam int K_WR   = 2;
	localparam int K_DEL  = 3;
	localparam int K_SRD  = 4;
	localparam int K_SWR  = 5;
	localparam int K_SDEL = 6;

	// Wanted access bits: read, write, delete
	localparam int WANT_W   = 3;
	localparam int WANT_RD  = 0;
	localparam int WANT_WR  = 1;
	localparam int WANT_DEL = 2;

endpackage

FILE: rtl/core/fsat_req_if.sv
// Request channel of the file share access table core.
// Depends on fsat_pkg for field widths.
interface fsat_req_if;
	import fsat_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [FILE_ID_W-1:0]  file_id;
	logic [ACCESS_W-1:0]   access_bits;
	logic [SHARE_W-1:0]    share_mode;

	modport source (output valid, req_type, file_id, access_bits, share_mode, input ready);
	modport sink (input valid, req_type, file_id, access_bits, share_mode, output ready);

endinterface

FILE: rtl/core/fsat_rsp_if.sv
// Response channel of the file share access table core.
// Depends on fsat_pkg for field widths.
interface fsat_rsp_if;
	import fsat_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [OPEN_AFTER_W-1:0] open_count_after;

	modport source (output valid, status, open_count_after, input ready);
	modport sink (input valid, status, open_count_after, output ready);

endinterface

FILE: rtl/core/file_share_access_table_core.sv
// File share access table core: share-mode accounting per file slot.
// Channels: req (sink) carries req_type, file_id, access_bits, share_mode;
// rsp (source) returns status and open_count_after, one result per request.
// Requests are checked against, counted into or counted out of the slot's
// seven counters, held in one synchronous RAM read at acceptance and
// written back when the result is registered.
// Path: an accepted request waits in the read stage, and its result is then
// registered once the result register is free or drains.
// Throughput: one request per cycle while rsp is ready; a write-back
// forwarding register lets consecutive requests to the same slot follow
// directly. The single RAM read and write port sets this rate.
// Reset: all control state clears and a sweep zeroes the table, one entry
// a cycle, over all NUM_FILES entries; req.ready stays low until it ends.
// Stall: while rsp.ready is low the result register holds, one more request
// can wait in the read stage, and then req.ready drops.
// Depends on fsat_pkg, fsat_req_if, fsat_rsp_if, fsat_table, fsat_update.
`include "file_share_access_table_core_defines.svh"

module file_share_access_table_core #(
	parameter int NUM_FILES  = fsat_pkg::NUM_FILES_DEF,
	parameter int COUNT_BITS = fsat_pkg::COUNT_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fsat_req_if.sink   req,
	fsat_rsp_if.source rsp
);
	import fsat_pkg::*;

	localparam int IDX_W   = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
	localparam int ENTRY_W = K_NUM * COUNT_BITS;

	typedef logic [IDX_W-1:0] slot_tab_t [FILE_ID_RANGE];

	// file_id modulo NUM_FILES, by table built at elaboration
	function automatic slot_tab_t build_slot_tab();
		slot_tab_t tab;
		int        r;
		r = 0;
		for (int v = 0; v < FILE_ID_RANGE; v++) begin
			tab[v] = IDX_W'(r);
			r = (r == NUM_FILES - 1) ? 0 : r + 1;
		end
		return tab;
	endfunction

	localparam slot_tab_t SLOT_TAB = build_slot_tab();

	logic                    accept;
	logic                    s1_retire;
	logic [IDX_W-1:0]        in_slot;
	logic [WANT_W-1:0]       in_want;

	logic                    valid_s1;
	logic [REQ_TYPE_W-1:0]   req_type_s1;
	logic [IDX_W-1:0]        slot_s1;
	logic [WANT_W-1:0]       want_s1;
	logic [SHARE_W-1:0]      share_s1;

	logic                    fwd_vld_q;
	logic [IDX_W-1:0]        fwd_slot_q;
	logic [ENTRY_W-1:0]      fwd_data_q;

	logic [ENTRY_W-1:0]      rd_data;
	logic [ENTRY_W-1:0]      cur_entry;
	logic [ENTRY_W-1:0]      new_entry;
	logic [STATUS_W-1:0]     upd_status;
	logic                    clr_busy;

	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [OPEN_AFTER_W-1:0] open_after_q;

	assign in_slot = SLOT_TAB[req.file_id];
	assign in_want[WANT_RD]  = |(req.access_bits & ACC_READ_MASK);
	assign in_want[WANT_WR]  = |(req.access_bits & ACC_WRITE_MASK);
	assign in_want[WANT_DEL] = |(req.access_bits & ACC_DELETE_MASK);

	assign s1_retire = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !clr_busy && (!valid_s1 || s1_retire);
	assign accept    = req.valid && req.ready;

	fsat_table #(
		.NUM_FILES  (NUM_FILES),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W),
		.ENTRY_W    (ENTRY_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_slot),
		.rd_data  (rd_data),
		.wr_en    (s1_retire),
		.wr_addr  (slot_s1),
		.wr_data  (new_entry),
		.clr_busy (clr_busy)
	);

	// Last write-back may not be visible in a read issued at the same edge
	assign cur_entry = (fwd_vld_q && fwd_slot_q == slot_s1) ? fwd_data_q : rd_data;

	fsat_update #(
		.COUNT_BITS (COUNT_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_update (
		.req_type   (req_type_s1),
		.want       (want_s1),
		.share_mode (share_s1),
		.cur_entry  (cur_entry),
		.new_entry  (new_entry),
		.status     (upd_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			slot_s1     <= in_slot;
			want_s1     <= in_want;
			share_s1    <= req.share_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (clr_busy) begin
			fwd_vld_q <= 1'b0;
		end else if (s1_retire) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_retire) begin
			fwd_slot_q <= slot_s1;
			fwd_data_q <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_retire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_retire) begin
			status_q     <= upd_status;
			open_after_q <= OPEN_AFTER_W'(new_entry[K_OPEN*COUNT_BITS +: COUNT_BITS]);
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = status_q;
	assign rsp.open_count_after = open_after_q;

	`FSAT_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !req.ready, "request taken during table clear")
	`FSAT_ASSERT_NOW(a_error_keeps_entry, s1_retire && upd_status != ST_OK, new_entry == cur_entry, "entry changed on error status")
	`FSAT_ASSERT_NEXT(a_s1_holds, valid_s1 && !s1_retire, valid_s1 && $stable(slot_s1), "read stage lost its request while stalled")
	`FSAT_ASSERT_NEXT(a_retire_gives_result, s1_retire, out_valid_q, "retired request produced no result")

endmodule

FILE: rtl/core/fsat_table.sv
// Counter table: one synchronous RAM of per-slot counter entries with a
// clearing sweep after reset. Depends on fsat_pkg.
module fsat_table #(
	parameter int NUM_FILES  = fsat_pkg::NUM_FILES_DEF,
	parameter int COUNT_BITS = fsat_pkg::COUNT_BITS_DEF,
	parameter int IDX_W      = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1,
	parameter int ENTRY_W    = fsat_pkg::K_NUM * COUNT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [ENTRY_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	output logic               clr_busy
);
	import fsat_pkg::*;

	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_FILES - 1);

	logic [ENTRY_W-1:0] mem [NUM_FILES];
	logic [ENTRY_W-1:0] rd_data_q;
	logic               clr_busy_q;
	logic [IDX_W-1:0]   clr_addr_q;

	// Sweep every entry to zero once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Read returns the old entry when the same address is written in that cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

FILE: rtl/core/fsat_update.sv
// Per-request update of one table entry: sharing check, count up, count
// down, with overflow and underflow detection. Depends on fsat_pkg.
module fsat_update #(
	parameter int COUNT_BITS = fsat_pkg::COUNT_BITS_DEF,
	parameter int ENTRY_W    = fsat_pkg::K_NUM * COUNT_BITS
) (
	input  logic [fsat_pkg::REQ_TYPE_W-1:0] req_type,
	input  logic [fsat_pkg::WANT_W-1:0]     want,
	input  logic [fsat_pkg::SHARE_W-1:0]    share_mode,
	input  logic [ENTRY_W-1:0]              cur_entry,
	output logic [ENTRY_W-1:0]              new_entry,
	output logic [fsat_pkg::STATUS_W-1:0]   status
);
	import fsat_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] cnt [K_NUM];
	logic [K_NUM-1:0]      touch;
	logic [K_NUM-1:0]      at_max;
	logic [K_NUM-1:0]      at_zero;
	logic                  violation;

	always_comb begin
		for (int k = 0; k < K_NUM; k++) begin
			cnt[k]     = cur_entry[k*COUNT_BITS +: COUNT_BITS];
			at_max[k]  = (cnt[k] == CNT_MAX);
			at_zero[k] = (cnt[k] == '0);
		end
		touch = {share_mode, want, 1'b1};

		violation = (want[WANT_RD]  && cnt[K_SRD]  != cnt[K_OPEN]) ||
		            (want[WANT_WR]  && cnt[K_SWR]  != cnt[K_OPEN]) ||
		            (want[WANT_DEL] && cnt[K_SDEL] != cnt[K_OPEN]) ||
		            (!share_mode[0] && cnt[K_RD]  != '0) ||
		            (!share_mode[1] && cnt[K_WR]  != '0) ||
		            (!share_mode[2] && cnt[K_DEL] != '0);

		status    = ST_OK;
		new_entry = cur_entry;
		// No read, write or delete wanted: pass through untouched
		if (|want) begin
			case (req_type)
				REQ_CHECK: begin
					if (violation) begin
						status = ST_VIOLATION;
					end
				end
				REQ_SET: begin
					if (|(touch & at_max)) begin
						status = ST_OVERFLOW;
					end else begin
						for (int k = 0; k < K_NUM; k++) begin
							new_entry[k*COUNT_BITS +: COUNT_BITS] =
								cnt[k] + COUNT_BITS'(touch[k]);
						end
					end
				end
				REQ_REMOVE: begin
					if (|(touch & at_zero)) begin
						status = ST_UNDERFLOW;
					end else begin
						for (int k = 0; k < K_NUM; k++) begin
							new_entry[k*COUNT_BITS +: COUNT_BITS] =
								cnt[k] - COUNT_BITS'(touch[k]);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: sim/tb_top.sv
// Testbench for the file share access table core: random and directed requests
// predicted in place, results checked in order. Uses fsat_pkg and the
// fsat_req_if / fsat_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_top;
	import fsat_pkg::*;

	localparam int NUM_SLOTS     = NUM_FILES_DEF;
	localparam int CNT_W         = COUNT_BITS_DEF;
	localparam int RANDOM_ITEMS  = 1350;
	localparam int FULL_SLOT     = 200;
	localparam int HOLDOFF_AT    = 30;
	localparam int HOLDOFF_LEN   = 400;
	localparam int DRAIN_CYCLES  = 16;

	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [ACCESS_W-1:0]   ACC_ANY    = ACC_READ_MASK | ACC_WRITE_MASK
		| ACC_DELETE_MASK;
	localparam logic [CNT_W-1:0]      CNT_MAX    = '1;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [FILE_ID_W-1:0]  file_id;
		logic [ACCESS_W-1:0]   access_bits;
		logic [SHARE_W-1:0]    share_mode;
	} share_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [OPEN_AFTER_W-1:0] open_after;
	} share_rsp_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

	logic clk;
	logic arst_n;

	fsat_req_if req_bus ();
	fsat_rsp_if rsp_bus ();

	file_share_access_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	logic [CNT_W-1:0] slot_counts [NUM_SLOTS][K_NUM];

	share_req_t pending_reqs [$];
	share_rsp_t expected_rsps [$];
	share_req_t next_req;
	share_rsp_t oldest_rsp;

	int error_count  = 0;
	int results_seen = 0;
	int burst_left;
	int gap_left;
	int holdoff_left;
	bit holdoff_done;
	int stall_left;
	int stall_phase;
	stall_mode_t stall_mode;

	// Table update for one request; returns the status and the open count after.
	function automatic share_rsp_t apply_share_request(share_req_t r);
		int slot;
		int k;
		logic want_rd, want_wr, want_del;
		logic [K_NUM-1:0] touch;
		logic [CNT_W-1:0] opens;
		share_rsp_t res;
		slot = int'(r.file_id) % NUM_SLOTS;
		want_rd  = |(r.access_bits & ACC_READ_MASK);
		want_wr  = |(r.access_bits & ACC_WRITE_MASK);
		want_del = |(r.access_bits & ACC_DELETE_MASK);
		touch = '0;
		touch[K_OPEN] = 1'b1;
		touch[K_RD]   = want_rd;
		touch[K_WR]   = want_wr;
		touch[K_DEL]  = want_del;
		touch[K_SRD]  = r.share_mode[WANT_RD];
		touch[K_SWR]  = r.share_mode[WANT_WR];
		touch[K_SDEL] = r.share_mode[WANT_DEL];
		res.status = ST_OK;
		if (want_rd || want_wr || want_del) begin
			opens = slot_counts[slot][K_OPEN];
			case (r.req_type)
				REQ_CHECK: begin
					if ((want_rd && slot_counts[slot][K_SRD] != opens) ||
						(want_wr && slot_counts[slot][K_SWR] != opens) ||
						(want_del && slot_counts[slot][K_SDEL] != opens) ||
						(!r.share_mode[WANT_RD] && slot_counts[slot][K_RD] != 0) ||
						(!r.share_mode[WANT_WR] && slot_counts[slot][K_WR] != 0) ||
						(!r.share_mode[WANT_DEL] && slot_counts[slot][K_DEL] != 0))
						res.status = ST_VIOLATION;
				end
				REQ_SET: begin
					for (k = 0; k < K_NUM; k++)
						if (touch[k] && slot_counts[slot][k] == CNT_MAX)
							res.status = ST_OVERFLOW;
					if (res.status == ST_OK)
						for (k = 0; k < K_NUM; k++)
							if (touch[k])
								slot_counts[slot][k] = slot_counts[slot][k] + 1'b1;
				end
				REQ_REMOVE: begin
					for (k = 0; k < K_NUM; k++)
						if (touch[k] && slot_counts[slot][k] == 0)
							res.status = ST_UNDERFLOW;
					if (res.status == ST_OK)
						for (k = 0; k < K_NUM; k++)
							if (touch[k])
								slot_counts[slot][k] = slot_counts[slot][k] - 1'b1;
				end
				default: ;
			endcase
		end
		res.open_after = slot_counts[slot][K_OPEN][OPEN_AFTER_W-1:0];
		return res;
	endfunction

	function automatic logic [ACCESS_W-1:0] pick_mask();
		logic [ACCESS_W-1:0] m;
		case ($urandom_range(0, 9))
			0, 1: m = $urandom & ~ACC_ANY;
			2: m = $urandom;
			3: m = '1;
			default: begin
				m = '0;
				if ($urandom_range(0, 1))
					m |= $urandom_range(0, 1) ? 32'h0000_0001 : 32'h0000_0020;
				if ($urandom_range(0, 1))
					m |= $urandom_range(0, 1) ? 32'h0000_0002 : 32'h0000_0004;
				if ($urandom_range(0, 2) == 0)
					m |= ACC_DELETE_MASK;
				if ($urandom_range(0, 3) == 0)
					m |= $urandom & ~ACC_ANY;
				if (m == '0)
					m = ACC_READ_MASK;
			end
		endcase
		return m;
	endfunction

	task automatic queue_req(input logic [REQ_TYPE_W-1:0] rt, input int id,
		input logic [ACCESS_W-1:0] m, input logic [SHARE_W-1:0] s);
		share_req_t r;
		r.req_type    = rt;
		r.file_id     = id[FILE_ID_W-1:0];
		r.access_bits = m;
		r.share_mode  = s;
		pending_reqs.push_back(r);
	endtask

	task automatic note_mismatch(input string what, input int exp_v, input int act_v);
		error_count++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v,
			act_v);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Request driver: bursts of transfers separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid       <= 1'b0;
			req_bus.req_type    <= '0;
			req_bus.file_id     <= '0;
			req_bus.access_bits <= '0;
			req_bus.share_mode  <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req_bus.valid && req_bus.ready)
				expected_rsps.push_back(apply_share_request({req_bus.req_type,
					req_bus.file_id, req_bus.access_bits, req_bus.share_mode}));
			if (!req_bus.valid || req_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_bus.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					next_req = pending_reqs.pop_front();
					req_bus.valid       <= 1'b1;
					req_bus.req_type    <= next_req.req_type;
					req_bus.file_id     <= next_req.file_id;
					req_bus.access_bits <= next_req.access_bits;
					req_bus.share_mode  <= next_req.share_mode;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Response ready: changing stall patterns, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			holdoff_left = 0;
			holdoff_done = 1'b0;
			stall_left = 0;
			stall_phase = 0;
			stall_mode = STALL_NONE;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			rsp_bus.ready <= 1'b0;
		end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF_LEN;
			rsp_bus.ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				case ($urandom_range(0, 2))
					0: stall_mode = STALL_NONE;
					1: stall_mode = STALL_RANDOM;
					default: stall_mode = STALL_PERIODIC;
				endcase
				stall_left = $urandom_range(32, 400);
			end else begin
				stall_left--;
			end
			stall_phase++;
			case (stall_mode)
				STALL_NONE: rsp_bus.ready <= 1'b1;
				STALL_RANDOM: rsp_bus.ready <= ($urandom_range(0, 2) != 0);
				default: rsp_bus.ready <= (stall_phase % 4 != 0);
			endcase
		end
	end

	// Result checker: compare every transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			results_seen++;
			if (expected_rsps.size() == 0) begin
				note_mismatch("unexpected result, status", -1, int'(rsp_bus.status));
			end else begin
				oldest_rsp = expected_rsps.pop_front();
				if (rsp_bus.status !== oldest_rsp.status)
					note_mismatch("status", int'(oldest_rsp.status),
						int'(rsp_bus.status));
				if (rsp_bus.open_count_after !== oldest_rsp.open_after)
					note_mismatch("open_count_after", int'(oldest_rsp.open_after),
						int'(rsp_bus.open_count_after));
			end
		end
	end

	initial begin
		share_req_t open_log [$];
		share_req_t r;
		int hot_slots [8];
		int i;
		int s;
		int idx;
		int pick;
		int slot;
		arst_n = 1'b0;
		for (s = 0; s < NUM_SLOTS; s++)
			for (i = 0; i < K_NUM; i++)
				slot_counts[s][i] = '0;

		// Directed: bypass, underflow, sharing rules, unused code, extremes.
		queue_req(REQ_CHECK, 0, 32'h0, 3'd0);
		queue_req(REQ_SET, 255, ~ACC_ANY, 3'd7);
		queue_req(REQ_REMOVE, 1, ~ACC_ANY, 3'd0);
		queue_req(REQ_REMOVE, 2, ACC_READ_MASK, 3'd0);
		queue_req(REQ_SET, 3, 32'h0000_0001, 3'd1);
		queue_req(REQ_CHECK, 3, 32'h0000_0020, 3'd1);
		queue_req(REQ_CHECK, 3, 32'h0000_0002, 3'd7);
		queue_req(REQ_CHECK, 3, 32'h0000_0001, 3'd0);
		queue_req(REQ_SET, 3, 32'h0000_0004, 3'd3);
		queue_req(REQ_CHECK, 3, ACC_DELETE_MASK, 3'd7);
		queue_req(REQ_SET, 4, 32'hFFFF_FFFF, 3'd7);
		queue_req(REQ_CHECK, 4, 32'hFFFF_FFFF, 3'd7);
		queue_req(REQ_CHECK, 4, ACC_DELETE_MASK, 3'd3);
		queue_req(REQ_REMOVE, 4, 32'hFFFF_FFFF, 3'd7);
		queue_req(REQ_REMOVE, 4, 32'hFFFF_FFFF, 3'd7);
		queue_req(REQ_UNUSED, 5, 32'hFFFF_FFFF, 3'd7);
		queue_req(REQ_REMOVE, 3, 32'h0000_0001, 3'd0);
		queue_req(REQ_REMOVE, 3, 32'h0000_0006, 3'd1);
		queue_req(REQ_REMOVE, 3, 32'h0000_0004, 3'd2);
		queue_req(REQ_CHECK, 255, 32'h0000_0001, 3'd0);

		// A few mixed requests on one busy slot.
		queue_req(REQ_SET, FULL_SLOT, 32'h0000_0002, 3'd4);
		queue_req(REQ_CHECK, FULL_SLOT, 32'h0000_0001, 3'd0);
		queue_req(REQ_REMOVE, FULL_SLOT, 32'h0000_0001, 3'd0);
		queue_req(REQ_SET, FULL_SLOT, 32'h0000_0020, 3'd0);

		// Random: opens, matched and unmatched closes, checks and unused codes, mostly on eight busy slots.
		hot_slots[0] = 0;
		hot_slots[1] = 255;
		hot_slots[2] = FULL_SLOT;
		for (i = 3; i < 8; i++)
			hot_slots[i] = $urandom_range(0, NUM_SLOTS - 1);
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0)
				slot = $urandom_range(0, NUM_SLOTS - 1);
			else
				slot = hot_slots[$urandom_range(0, 7)];
			if (pick < 40) begin
				r.req_type = REQ_SET;
				r.file_id = slot[FILE_ID_W-1:0];
				r.access_bits = pick_mask();
				r.share_mode = SHARE_W'($urandom_range(0, 7));
				open_log.push_back(r);
				pending_reqs.push_back(r);
			end else if (pick < 70) begin
				if (open_log.size() > 0 && $urandom_range(0, 9) < 7) begin
					idx = $urandom_range(0, open_log.size() - 1);
					r = open_log[idx];
					open_log.delete(idx);
					r.req_type = REQ_REMOVE;
					pending_reqs.push_back(r);
				end else begin
					queue_req(REQ_REMOVE, slot, pick_mask(),
						SHARE_W'($urandom_range(0, 7)));
				end
			end else if (pick < 95) begin
				if (open_log.size() > 0 && $urandom_range(0, 1))
					slot = int'(open_log[$urandom_range(0, open_log.size() - 1)].file_id);
				queue_req(REQ_CHECK, slot, pick_mask(), SHARE_W'($urandom_range(0, 7)));
			end else begin
				queue_req(REQ_UNUSED, slot, pick_mask(), SHARE_W'($urandom_range(0, 7)));
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_bus.valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
